// File: rtl/core/ravg_pkg.sv
// ----------------------------------------------------------------------------
// ravg_pkg
// Shared constants and controller/datapath command and status types for the
// running average with spread block.
// ----------------------------------------------------------------------------
package ravg_pkg;

  localparam int MAX_SPAN_DEF = 64;
  localparam int SAMPLE_W     = 16;
  localparam int SPAN_W       = 7;
  localparam int COUNT_W      = 7;
  localparam int SPREAD_W     = 16;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 7'd64;

  typedef struct packed {
    logic load;
    logic update;
    logic div_step;
    logic walk_step;
    logic sqrt_step;
    logic result_load;
    logic cnt_clr;
    logic cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic walk_last;
    logic sqrt_last;
  } sts_t;

endpackage

// File: rtl/core/ravg_ifs.sv
// ----------------------------------------------------------------------------
// ravg channel interfaces
// Valid/ready channels for samples, results and the span register write.
// ----------------------------------------------------------------------------
interface ravg_in_if;
  logic                          valid;
  logic                          ready;
  logic [ravg_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ravg_out_if;
  logic                          valid;
  logic                          ready;
  logic [ravg_pkg::SAMPLE_W-1:0] average;
  logic [ravg_pkg::COUNT_W-1:0]  sample_count;
  logic [ravg_pkg::SPREAD_W-1:0] spread;
  modport source (output valid, output average, output sample_count, output spread,
                  input ready);
  modport sink   (input valid, input average, input sample_count, input spread,
                  output ready);
endinterface

interface ravg_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ravg_pkg::SPAN_W-1:0] span;
  modport source (output valid, output span, input ready);
  modport sink   (input valid, input span, output ready);
endinterface

// File: rtl/core/running_average_with_spread.sv
// ----------------------------------------------------------------------------
// running_average_with_spread
// Windowed mean of 16-bit samples with the root of summed squared deviations.
//
// Channels: in_ch carries one sample per transaction, out_ch one result
// (average, sample_count, spread) per sample, cfg_ch writes the window span
// and clears the window. cfg_ch is always ready; write it only while idle.
// One sample is processed at a time. Each accepted sample passes through a
// window update, a bit-serial divider, a walk over the ring RAM (one entry
// per cycle through one read port and one 16x16 multiplier), a bit-pair
// square root and a result load. A new sample is accepted once the previous
// one has reached the output register. A pending result is held in the
// output register while out_ch is stalled; the next sample is accepted
// meanwhile and waits before its result load until the register is free.
// Reset sets span to 64 and empties the window; unwritten ring entries are
// masked by the fill count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module running_average_with_spread #(
  parameter int MAX_SPAN = ravg_pkg::MAX_SPAN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ravg_cfg_if.sink      cfg_ch,
  ravg_in_if.sink       in_ch,
  ravg_out_if.source    out_ch
);

  ravg_pkg::cmd_t cmd;
  ravg_pkg::sts_t sts;

  ravg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ravg_dp #(
    .MAX_SPAN (MAX_SPAN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_ch.valid),
    .cfg_span         (cfg_ch.span),
    .cfg_ready        (cfg_ch.ready),
    .in_sample        (in_ch.sample),
    .cmd              (cmd),
    .sts              (sts),
    .out_average      (out_ch.average),
    .out_sample_count (out_ch.sample_count),
    .out_spread       (out_ch.spread)
  );

endmodule

// File: rtl/core/ravg_ram.sv
// ----------------------------------------------------------------------------
// ravg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ravg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ravg_ctrl.sv
// ----------------------------------------------------------------------------
// ravg_ctrl
// Sequencer: accept, window update, divide, window walk, root, result.
// ----------------------------------------------------------------------------
module ravg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ravg_pkg::sts_t sts,
  output ravg_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update  = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_WALK;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_SQRT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.result_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.result_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/ravg_dp.sv
// ----------------------------------------------------------------------------
// ravg_dp
// Window datapath: ring RAM, running sum, serial divider, squared deviation
// accumulator, serial square root and result register.
// ----------------------------------------------------------------------------
module ravg_dp #(
  parameter int MAX_SPAN = ravg_pkg::MAX_SPAN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [ravg_pkg::SPAN_W-1:0]   cfg_span,
  output logic                          cfg_ready,
  input  logic [ravg_pkg::SAMPLE_W-1:0] in_sample,
  input  ravg_pkg::cmd_t                cmd,
  output ravg_pkg::sts_t                sts,
  output logic [ravg_pkg::SAMPLE_W-1:0] out_average,
  output logic [ravg_pkg::COUNT_W-1:0]  out_sample_count,
  output logic [ravg_pkg::SPREAD_W-1:0] out_spread
);

  localparam int SW     = ravg_pkg::SAMPLE_W;
  localparam int AW     = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  localparam int CNT_W  = $clog2(MAX_SPAN + 1);
  localparam int SUM_W  = SW + CNT_W;
  localparam int ROOT_W = SW + (CNT_W + 1) / 2;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int PROD_W = 2 * SW;
  localparam int CMAX0  = (MAX_SPAN + 2 > SUM_W) ? MAX_SPAN + 2 : SUM_W;
  localparam int CMAX   = (CMAX0 > ROOT_W) ? CMAX0 : ROOT_W;
  localparam int CTR_W  = $clog2(CMAX + 1);
  localparam logic [ROOT_W-1:0] SPREAD_SAT = ROOT_W'((1 << ravg_pkg::SPREAD_W) - 1);

  logic [ravg_pkg::SPAN_W-1:0] span_r;
  logic [CNT_W-1:0]  eff;
  logic [CNT_W-1:0]  filled_r, filled_nxt;
  logic [AW-1:0]     pos_r, pos_cur, pos_nxt;
  logic [CNT_W-1:0]  pos_inc;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SW-1:0]     smp_r;
  logic              full;
  logic [CTR_W-1:0]  cnt_r;

  logic [SUM_W-1:0]  dq_r;
  logic [CNT_W-1:0]  drem_r;
  logic [CNT_W:0]    drem_ext;
  logic              dge;

  logic              rd_v_r, inr_r, pv_r;
  logic              issue;
  logic [SW-1:0]     mean;
  logic [SW-1:0]     ent;
  logic [SW-1:0]     dev;
  logic [PROD_W-1:0] prod_r;
  logic [SQ_W-1:0]   sq_r;

  logic [ROOT_W:0]   srem_r;
  logic [ROOT_W-1:0] sroot_r;
  logic [ROOT_W+2:0] srem_sh;
  logic [ROOT_W+2:0] strial;
  logic              sge;

  logic              we;
  logic [AW-1:0]     raddr;
  logic [SW-1:0]     rdata;

  logic [SW-1:0]               average_r;
  logic [ravg_pkg::COUNT_W-1:0] count_r;
  logic [ravg_pkg::SPREAD_W-1:0] spread_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (span_r == '0) begin
      eff = CNT_W'(1);
    end else if (32'(span_r) > MAX_SPAN) begin
      eff = CNT_W'(MAX_SPAN);
    end else begin
      eff = CNT_W'(span_r);
    end
  end

  assign pos_cur = (CNT_W'(pos_r) >= eff) ? '0 : pos_r;
  assign pos_inc = CNT_W'(pos_cur) + CNT_W'(1);
  assign pos_nxt = (pos_inc >= eff) ? '0 : AW'(pos_inc);
  assign full    = (filled_r == eff);

  always_comb begin
    filled_nxt = full ? filled_r : filled_r + CNT_W'(1);
    sum_nxt    = sum_r - (full ? SUM_W'(rdata) : '0) + SUM_W'(smp_r);
  end

  assign we    = cmd.update;
  assign issue = cmd.walk_step && (CNT_W'(cnt_r) < eff) && (cnt_r < CTR_W'(MAX_SPAN));
  assign raddr = cmd.load ? pos_cur : cnt_r[AW-1:0];

  ravg_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SPAN)
  ) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (pos_cur),
    .wdata (smp_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign drem_ext = {drem_r, dq_r[SUM_W-1]};
  assign dge      = (drem_ext >= {1'b0, filled_r});

  assign mean = dq_r[SW-1:0];
  assign ent  = inr_r ? rdata : '0;
  assign dev  = (ent >= mean) ? ent - mean : mean - ent;

  assign srem_sh = {srem_r, sq_r[SQ_W-1:SQ_W-2]};
  assign strial  = (ROOT_W+3)'({sroot_r, 2'b01});
  assign sge     = (srem_sh >= strial);

  assign sts.div_last  = (cnt_r == CTR_W'(SUM_W - 1));
  assign sts.walk_last = (cnt_r == CTR_W'(eff) + CTR_W'(1));
  assign sts.sqrt_last = (cnt_r == CTR_W'(ROOT_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r   <= ravg_pkg::SPAN_RESET;
      filled_r <= '0;
      pos_r    <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      rd_v_r   <= 1'b0;
      pv_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        span_r   <= cfg_span;
        filled_r <= '0;
        pos_r    <= '0;
        sum_r    <= '0;
      end else if (cmd.update) begin
        filled_r <= filled_nxt;
        pos_r    <= pos_nxt;
        sum_r    <= sum_nxt;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CTR_W'(1);
      end
      rd_v_r <= issue;
      pv_r   <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r <= in_sample;
    end
    if (cmd.update) begin
      dq_r    <= sum_nxt;
      drem_r  <= '0;
      sq_r    <= '0;
      srem_r  <= '0;
      sroot_r <= '0;
    end else begin
      if (cmd.div_step) begin
        dq_r   <= {dq_r[SUM_W-2:0], dge};
        drem_r <= dge ? CNT_W'(drem_ext - {1'b0, filled_r}) : CNT_W'(drem_ext);
      end
      if (pv_r) begin
        sq_r <= sq_r + SQ_W'(prod_r);
      end else if (cmd.sqrt_step) begin
        sq_r    <= {sq_r[SQ_W-3:0], 2'b00};
        srem_r  <= sge ? (ROOT_W+1)'(srem_sh - strial) : (ROOT_W+1)'(srem_sh);
        sroot_r <= {sroot_r[ROOT_W-2:0], sge};
      end
    end
    if (rd_v_r) begin
      prod_r <= PROD_W'(dev) * PROD_W'(dev);
    end
    inr_r <= (CNT_W'(cnt_r) < filled_r);
    if (cmd.result_load) begin
      average_r <= mean;
      count_r   <= ravg_pkg::COUNT_W'(filled_r);
      spread_r  <= (sroot_r > SPREAD_SAT) ? ravg_pkg::SPREAD_W'(SPREAD_SAT)
                                          : ravg_pkg::SPREAD_W'(sroot_r);
    end
  end

  assign out_average      = average_r;
  assign out_sample_count = count_r;
  assign out_spread       = spread_r;

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for running_average_with_spread. Samples go in over a
// valid/ready channel, in bursts with random gaps while the sender is
// paced. Each accepted sample advances a local window model that predicts
// average, sample count and spread. A checker compares every accepted result
// against the oldest prediction. The span register is written only while no
// result is outstanding. The run covers directed edge cases first, then random
// phases with spans that range over every setting.
// ----------------------------------------------------------------------------
module tb;
  import ravg_pkg::*;

  localparam int WINDOW_MAX   = MAX_SPAN_DEF;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int SETTLE_CYCLES = WINDOW_MAX + 49 + 50;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic [COUNT_W-1:0]  sample_count;
    logic [SPREAD_W-1:0] spread;
  } window_stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ravg_cfg_if cfg_if ();
  ravg_in_if  in_if ();
  ravg_out_if out_if ();

  running_average_with_spread uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [SAMPLE_W-1:0] win_ring [WINDOW_MAX];
  logic [21:0]         win_sum;
  int                  win_filled;
  int                  win_pos;
  logic [SAMPLE_W-1:0] win_mean;
  logic [SPAN_W-1:0]   win_span;

  window_stats_t expected_stats [$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  samples_sent = 0;
  int  burst_left = 0;
  int  ready_run = 0;
  int  ready_stall = 0;
  bit  pace_sender = 1'b1;
  bit  pace_receiver = 1'b1;

  function automatic int window_len();
    if (win_span == 0) return 1;
    if (win_span > WINDOW_MAX) return WINDOW_MAX;
    return int'(win_span);
  endfunction

  function automatic void clear_window();
    foreach (win_ring[i]) win_ring[i] = '0;
    win_sum    = '0;
    win_filled = 0;
    win_pos    = 0;
    win_mean   = '0;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned root;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd1 << 20;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    root = lo;
    return root;
  endfunction

  function automatic window_stats_t advance_window(logic [SAMPLE_W-1:0] smp);
    int                len;
    int                pos;
    longint unsigned   sq_sum;
    longint unsigned   dev;
    longint unsigned   diff;
    window_stats_t     res;
    len = window_len();
    pos = win_pos;
    if (pos >= len) pos = 0;
    if (win_filled < len) win_filled++;
    else win_sum = win_sum - win_ring[pos];
    win_ring[pos] = smp;
    win_sum  = win_sum + smp;
    win_mean = SAMPLE_W'(win_sum / win_filled);
    pos++;
    if (pos >= len) pos = 0;
    win_pos = pos;
    sq_sum = 0;
    for (int i = 0; i < len; i++) begin
      if (win_ring[i] >= win_mean) diff = longint'(win_ring[i]) - longint'(win_mean);
      else diff = longint'(win_mean) - longint'(win_ring[i]);
      sq_sum += diff * diff;
    end
    dev = floor_root(sq_sum);
    if (dev > 65535) dev = 65535;
    res.average      = win_mean;
    res.sample_count = COUNT_W'(win_filled);
    res.spread       = dev[SPREAD_W-1:0];
    return res;
  endfunction

  function automatic void flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  always @(negedge clk) begin
    if (!pace_receiver) begin
      out_if.ready <= 1'b1;
    end else if (ready_run > 0) begin
      out_if.ready <= 1'b1;
      ready_run--;
    end else if (ready_stall > 0) begin
      out_if.ready <= 1'b0;
      ready_stall--;
    end else begin
      ready_run   = $urandom_range(1, 40);
      ready_stall = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 130)
                                                  : $urandom_range(1, 25);
      out_if.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    window_stats_t want;
    window_stats_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else if (rst_n && out_if.valid && out_if.ready) begin
      got.average      = out_if.average;
      got.sample_count = out_if.sample_count;
      got.spread       = out_if.spread;
      if (expected_stats.size() == 0) begin
        flag_error($sformatf("unexpected result avg=%0d cnt=%0d spread=%0d",
                             got.average, got.sample_count, got.spread));
      end else begin
        want = expected_stats.pop_front();
        if (got !== want)
          flag_error($sformatf(
            "mismatch: expected avg=%0d cnt=%0d spread=%0d, got avg=%0d cnt=%0d spread=%0d",
            want.average, want.sample_count, want.spread,
            got.average, got.sample_count, got.spread));
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    int gap;
    @(negedge clk);
    if (pace_sender && burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 10);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_if.valid  <= 1'b1;
    in_if.sample <= smp;
    do @(posedge clk); while (!in_if.ready);
    expected_stats.push_back(advance_window(smp));
    samples_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (expected_stats.size() == 0);
  endtask

  task automatic write_span(input logic [SPAN_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.span  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    win_span = value;
    clear_window();
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] base);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return SAMPLE_W'($urandom_range(0, 65535));
      5, 6:          return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      default:       return base ^ SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_reset_window();
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h0001);
    wait_idle();
  endtask

  task automatic test_single_entry();
    write_span(7'd1);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'd12345);
  endtask

  task automatic test_zero_span();
    write_span(7'd0);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
  endtask

  task automatic test_oversize_span();
    write_span(7'd127);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
  endtask

  task automatic test_ring_wrap();
    write_span(7'd3);
    send_sample(16'd10);
    send_sample(16'd20);
    send_sample(16'd30);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'd7);
  endtask

  task automatic test_random_phases();
    int                  target;
    int                  count;
    logic [SPAN_W-1:0]   next_span;
    logic [SAMPLE_W-1:0] base;
    target = samples_sent + RANDOM_ITEMS;
    while (samples_sent < target) begin
      case ($urandom_range(0, 9))
        0:       next_span = 7'd0;
        1:       next_span = 7'd1;
        2:       next_span = 7'd64;
        3:       next_span = SPAN_W'($urandom_range(65, 127));
        4:       next_span = 7'd2;
        default: next_span = SPAN_W'($urandom_range(1, 64));
      endcase
      write_span(next_span);
      pace_sender   = ($urandom_range(0, 3) != 0);
      pace_receiver = ($urandom_range(0, 3) != 0);
      count = $urandom_range(1, 2 * window_len() + 4);
      if (count > target - samples_sent) count = target - samples_sent;
      base = SAMPLE_W'($urandom_range(0, 65535));
      repeat (count) send_sample(pick_sample(base));
    end
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.span  = '0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    win_span = SPAN_RESET;
    clear_window();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_window();
    test_single_entry();
    test_zero_span();
    test_oversize_span();
    test_ring_wrap();
    test_random_phases();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_stats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
